/* hdl/secant_root_iteration_engine_defines.svh */
// ---------------------------------------------------------------------------
// secant root iteration engine assertion macros
// shared property forms for the engine's concurrent checks
// ---------------------------------------------------------------------------
`ifndef SECANT_ROOT_ITERATION_ENGINE_DEFINES_SVH
`define SECANT_ROOT_ITERATION_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define SRIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SRIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/srie_pkg.sv */
// ---------------------------------------------------------------------------
// srie_pkg
// types, codes and constants shared by the secant root engine modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package srie_pkg;

  localparam int DEF_DATA_WIDTH    = 32;
  localparam int DEF_FRACTION_BITS = 16;
  localparam int DEF_COUNT_WIDTH   = 16;

  localparam int TOL_WIDTH       = 31;
  localparam int LIMIT_WIDTH     = 16;
  localparam int CFG_DATA_WIDTH  = TOL_WIDTH;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [TOL_WIDTH-1:0]   TOL_RESET   = 31'd66;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'd50;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_VALUE_TOL = 2'd0,
    REG_POINT_TOL = 2'd1,
    REG_SLOPE_TOL = 2'd2,
    REG_MAX_ITER  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_VALUE = 1'b1
  } op_t;

  typedef enum logic {
    KIND_REQUEST = 1'b0,
    KIND_ROOT    = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_SAME_POINT  = 2'd1,
    STAT_FLAT_SLOPE  = 2'd2,
    STAT_NO_CONVERGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_WAIT_A = 2'd1,
    PH_WAIT_B = 2'd2,
    PH_ITER   = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_CHECK,
    S_DIVIDE,
    S_QSAT,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_SUM,
    S_UPDATE,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    LOAD_NONE,
    LOAD_START,
    LOAD_FIRST,
    LOAD_SORT,
    LOAD_NEXT
  } load_sel_t;

  typedef enum logic [2:0] {
    PEND_NONE,
    PEND_START,
    PEND_PREV,
    PEND_FINAL,
    PEND_NEXT
  } pend_sel_t;

  typedef struct packed {
    logic [TOL_WIDTH-1:0]   value_tol;
    logic [TOL_WIDTH-1:0]   point_tol;
    logic [TOL_WIDTH-1:0]   slope_tol;
    logic [LIMIT_WIDTH-1:0] max_iter;
  } cfg_t;

  typedef struct packed {
    load_sel_t load_sel;
    pend_sel_t pend_sel;
    status_t   final_status;
    logic      diff;
    logic      capture;
    logic      div_start;
    logic      qsat;
    logic      mul_lo;
    logic      mul_hi;
    logic      mul_sum;
    logic      update;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic value_open;
    logic below_limit;
    logic same_point;
    logic flat_slope;
    logic div_busy;
  } dp_status_t;

endpackage

/* hdl/srie_regs.sv */
// ---------------------------------------------------------------------------
// srie_regs
// tolerance and iteration limit registers behind the write port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srie_regs import srie_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
  input  logic [CFG_DATA_WIDTH-1:0]  wr_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.value_tol <= TOL_RESET;
      cfg.point_tol <= TOL_RESET;
      cfg.slope_tol <= TOL_RESET;
      cfg.max_iter  <= LIMIT_RESET;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_VALUE_TOL: cfg.value_tol <= wr_data[TOL_WIDTH-1:0];
        REG_POINT_TOL: cfg.point_tol <= wr_data[TOL_WIDTH-1:0];
        REG_SLOPE_TOL: cfg.slope_tol <= wr_data[TOL_WIDTH-1:0];
        REG_MAX_ITER:  cfg.max_iter  <= wr_data[LIMIT_WIDTH-1:0];
      endcase
    end
  end

endmodule

/* hdl/srie_divider.sv */
// ---------------------------------------------------------------------------
// srie_divider
// radix-2 restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srie_divider import srie_pkg::*; #(
  parameter int DATA_WIDTH    = DEF_DATA_WIDTH,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [DATA_WIDTH+FRACTION_BITS-1:0] dividend,
  input  logic [DATA_WIDTH:0]                 divisor,
  output logic                                busy,
  output logic [DATA_WIDTH+FRACTION_BITS-1:0] quotient
);

  localparam int NUM_W = DATA_WIDTH + FRACTION_BITS;
  localparam int REM_W = DATA_WIDTH + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dvs;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;

  logic [REM_W:0]   shifted;
  logic [REM_W:0]   trial;
  logic             fits;

  always_comb begin
    shifted = {rem, quo[NUM_W-1]};
    fits    = shifted >= {1'b0, dvs};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= fits ? trial[REM_W-1:0] : shifted[REM_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign busy     = cnt != '0;
  assign quotient = quo;

endmodule

/* hdl/srie_datapath.sv */
// ---------------------------------------------------------------------------
// srie_datapath
// point and value registers, tolerance checks, secant step arithmetic
// and the result word register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srie_datapath import srie_pkg::*; #(
  parameter int DATA_WIDTH    = DEF_DATA_WIDTH,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
  input  logic                          clk,
  input  dp_cmd_t                       cmd,
  input  cfg_t                          cfg,
  input  logic signed [DATA_WIDTH-1:0]  start_a,
  input  logic signed [DATA_WIDTH-1:0]  start_b,
  input  logic signed [DATA_WIDTH-1:0]  func_value,
  output dp_status_t                    flags,
  output logic                          res_kind,
  output logic signed [DATA_WIDTH-1:0]  res_point,
  output logic [1:0]                    res_status,
  output logic [COUNT_WIDTH-1:0]        res_iterations
);

  localparam int DW    = DATA_WIDTH;
  localparam int NUM_W = DW + FRACTION_BITS;
  localparam int MAG_W = DW + 1;
  localparam int LO_W  = (DW + 2) / 2;
  localparam int PP_W  = DW + LO_W;
  localparam int ACC_W = 2 * DW + 1;
  localparam int CMP_W = (MAG_W > TOL_WIDTH) ? MAG_W : TOL_WIDTH;
  localparam int LIM_W = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

  localparam logic [DW-1:0]          SAT_NEG    = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0]          SAT_POS    = {1'b0, {(DW-1){1'b1}}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = '1;

  logic signed [DW-1:0]    cur_pt;
  logic signed [DW-1:0]    cur_val;
  logic signed [DW-1:0]    prev_pt;
  logic signed [DW-1:0]    prev_val;
  logic [COUNT_WIDTH-1:0]  count;
  logic [MAG_W-1:0]        dx;
  logic [MAG_W-1:0]        dfv;
  logic [MAG_W-1:0]        dx_mag_r;
  logic                    neg_q;
  logic                    neg_p;
  logic [DW-1:0]           q_mag;
  logic [PP_W-1:0]         pp;
  logic [ACC_W-1:0]        acc;
  kind_t                   pend_kind;
  status_t                 pend_status;
  logic signed [DW-1:0]    pend_point;

  logic [DW-1:0]           cv_bits;
  logic [DW-1:0]           cv_mag;
  logic [MAG_W-1:0]        dx_mag;
  logic [MAG_W-1:0]        dfv_mag;
  logic                    div_busy;
  logic [NUM_W-1:0]        quotient;
  logic                    q_ovf;
  logic [LO_W-1:0]         mul_b;
  logic [PP_W-1:0]         mul_out;
  logic [ACC_W-1:0]        pm;
  logic                    p_ovf;
  logic [DW-1:0]           p_mag;
  logic [MAG_W-1:0]        step_sum;
  logic [DW-1:0]           nxt_sat;

  // magnitudes and tolerance checks
  always_comb begin
    cv_bits = cur_val;
    cv_mag  = cv_bits[DW-1] ? (~cv_bits + DW'(1)) : cv_bits;
    dx_mag  = dx[DW] ? (~dx + MAG_W'(1)) : dx;
    dfv_mag = dfv[DW] ? (~dfv + MAG_W'(1)) : dfv;
    flags.value_open  = CMP_W'(cv_mag) > CMP_W'(cfg.value_tol);
    flags.below_limit = LIM_W'(count) < LIM_W'(cfg.max_iter);
    flags.same_point  = CMP_W'(dx_mag) < CMP_W'(cfg.point_tol);
    flags.flat_slope  = (CMP_W'(dfv_mag) < CMP_W'(cfg.slope_tol)) || (dfv_mag == '0);
    flags.div_busy    = div_busy;
  end

  srie_divider #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (cmd.div_start & 1'b0),
    .start    (cmd.div_start),
    .dividend (NUM_W'(cv_mag) << FRACTION_BITS),
    .divisor  (dfv_mag),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // saturation of quotient and product, shared multiplier, next point
  always_comb begin
    q_ovf    = |quotient[NUM_W-1:DW-1];
    mul_b    = cmd.mul_hi ? LO_W'(dx_mag_r[MAG_W-1:LO_W]) : dx_mag_r[LO_W-1:0];
    mul_out  = PP_W'(q_mag) * PP_W'(mul_b);
    pm       = acc >> FRACTION_BITS;
    p_ovf    = |pm[ACC_W-1:DW-1];
    p_mag    = p_ovf ? (neg_p ? SAT_NEG : SAT_POS) : pm[DW-1:0];
    step_sum = {cur_pt[DW-1], cur_pt} + (neg_p ? {1'b0, p_mag} : (~{1'b0, p_mag} + MAG_W'(1)));
    if (step_sum[DW] != step_sum[DW-1]) begin
      nxt_sat = step_sum[DW] ? SAT_NEG : SAT_POS;
    end else begin
      nxt_sat = step_sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.load_sel)
      LOAD_START: begin
        cur_pt   <= start_a;
        prev_pt  <= start_b;
        cur_val  <= '0;
        prev_val <= '0;
        count    <= '0;
      end
      LOAD_FIRST: cur_val <= func_value;
      LOAD_SORT: begin
        if (cur_val > func_value) begin
          cur_pt   <= prev_pt;
          cur_val  <= func_value;
          prev_pt  <= cur_pt;
          prev_val <= cur_val;
        end else begin
          prev_val <= func_value;
        end
      end
      LOAD_NEXT: begin
        cur_val <= func_value;
        if (count != COUNT_FULL) begin
          count <= count + COUNT_WIDTH'(1);
        end
      end
      default: ;
    endcase

    if (cmd.diff) begin
      dx  <= {cur_pt[DW-1], cur_pt} - {prev_pt[DW-1], prev_pt};
      dfv <= {cur_val[DW-1], cur_val} - {prev_val[DW-1], prev_val};
    end

    if (cmd.capture) begin
      dx_mag_r <= dx_mag;
      neg_q    <= cv_bits[DW-1] ^ dfv[DW];
      neg_p    <= cv_bits[DW-1] ^ dfv[DW] ^ dx[DW];
    end

    if (cmd.qsat) begin
      q_mag <= q_ovf ? (neg_q ? SAT_NEG : SAT_POS) : quotient[DW-1:0];
    end

    if (cmd.mul_lo) begin
      pp <= mul_out;
    end
    if (cmd.mul_hi) begin
      acc <= ACC_W'(pp);
      pp  <= mul_out;
    end
    if (cmd.mul_sum) begin
      acc <= acc + (ACC_W'(pp) << LO_W);
    end

    if (cmd.update) begin
      prev_pt  <= cur_pt;
      prev_val <= cur_val;
      cur_pt   <= nxt_sat;
    end

    case (cmd.pend_sel)
      PEND_START: begin
        pend_kind   <= KIND_REQUEST;
        pend_point  <= start_a;
        pend_status <= STAT_OK;
      end
      PEND_PREV: begin
        pend_kind   <= KIND_REQUEST;
        pend_point  <= prev_pt;
        pend_status <= STAT_OK;
      end
      PEND_FINAL: begin
        pend_kind   <= KIND_ROOT;
        pend_point  <= cur_pt;
        pend_status <= cmd.final_status;
      end
      PEND_NEXT: begin
        pend_kind   <= KIND_REQUEST;
        pend_point  <= nxt_sat;
        pend_status <= STAT_OK;
      end
      default: ;
    endcase

    if (cmd.out_load) begin
      res_kind       <= pend_kind;
      res_point      <= pend_point;
      res_status     <= pend_status;
      res_iterations <= count;
    end
  end

endmodule

/* hdl/srie_ctrl.sv */
// ---------------------------------------------------------------------------
// srie_ctrl
// sequencer for the search phases and the steps of one secant update,
// owner of the handshake flags
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srie_ctrl import srie_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       operation,
  input  logic       out_stall,
  input  dp_status_t flags,
  output logic       in_stall,
  output logic       out_valid,
  output dp_cmd_t    cmd
);

  state_t  state;
  state_t  state_next;
  phase_t  phase;
  phase_t  phase_next;
  logic    out_free;
  logic    search_on;
  logic    stop;
  status_t final_code;

  always_comb begin
    out_free  = !out_valid || !out_stall;
    search_on = flags.value_open && flags.below_limit;
    stop      = !search_on || flags.same_point || flags.flat_slope;
    if (!search_on) begin
      final_code = flags.below_limit ? STAT_OK : STAT_NO_CONVERGE;
    end else if (flags.same_point) begin
      final_code = STAT_SAME_POINT;
    end else begin
      final_code = STAT_FLAT_SLOPE;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op_t'(operation) == OP_START) begin
            phase_next = PH_WAIT_A;
            state_next = S_EMIT;
          end else begin
            unique case (phase) inside
              PH_IDLE: ;
              PH_WAIT_A: begin
                phase_next = PH_WAIT_B;
                state_next = S_EMIT;
              end
              PH_WAIT_B, PH_ITER: state_next = S_DIFF;
            endcase
          end
        end
      end
      S_DIFF: state_next = S_CHECK;
      S_CHECK: begin
        if (stop) begin
          phase_next = PH_IDLE;
          state_next = S_EMIT;
        end else begin
          state_next = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (!flags.div_busy) begin
          state_next = S_QSAT;
        end
      end
      S_QSAT:    state_next = S_MUL_LO;
      S_MUL_LO:  state_next = S_MUL_HI;
      S_MUL_HI:  state_next = S_MUL_SUM;
      S_MUL_SUM: state_next = S_UPDATE;
      S_UPDATE: begin
        phase_next = PH_ITER;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd              = '0;
    cmd.load_sel     = LOAD_NONE;
    cmd.pend_sel     = PEND_NONE;
    cmd.final_status = final_code;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op_t'(operation) == OP_START) begin
            cmd.load_sel = LOAD_START;
            cmd.pend_sel = PEND_START;
          end else begin
            unique case (phase)
              PH_IDLE: ;
              PH_WAIT_A: begin
                cmd.load_sel = LOAD_FIRST;
                cmd.pend_sel = PEND_PREV;
              end
              PH_WAIT_B: cmd.load_sel = LOAD_SORT;
              PH_ITER:   cmd.load_sel = LOAD_NEXT;
            endcase
          end
        end
      end
      S_DIFF: cmd.diff = 1'b1;
      S_CHECK: begin
        cmd.capture   = 1'b1;
        cmd.div_start = !stop;
        if (stop) begin
          cmd.pend_sel = PEND_FINAL;
        end
      end
      S_DIVIDE:  ;
      S_QSAT:    cmd.qsat = 1'b1;
      S_MUL_LO:  cmd.mul_lo = 1'b1;
      S_MUL_HI:  cmd.mul_hi = 1'b1;
      S_MUL_SUM: cmd.mul_sum = 1'b1;
      S_UPDATE: begin
        cmd.update   = 1'b1;
        cmd.pend_sel = PEND_NEXT;
      end
      S_EMIT: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = state != S_IDLE;

endmodule

/* hdl/secant_root_iteration_engine.sv */
// ---------------------------------------------------------------------------
// secant_root_iteration_engine
// Secant root finder for a function evaluated outside the block. A start
// word gives two points and the block answers with a request for each; every
// value word then yields one result word: the next point to evaluate or a
// final root with its status. One input word is worked on at a time while
// the previous result may still wait in the output register. A start word or
// the first value goes straight to the output; a value that ends the search
// without a division passes the difference and check states; a secant step
// adds the divide on the radix-2 divider, one quotient bit per cycle, then
// saturation, a product formed in two halves on one multiplier and the update.
// Registers: value, point and slope tolerance, iteration limit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "secant_root_iteration_engine_defines.svh"

module secant_root_iteration_engine import srie_pkg::*; #(
  parameter int DATA_WIDTH    = DEF_DATA_WIDTH,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0]   wr_index,
  input  logic [CFG_DATA_WIDTH-1:0]    wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic signed [DATA_WIDTH-1:0] start_a,
  input  logic signed [DATA_WIDTH-1:0] start_b,
  input  logic signed [DATA_WIDTH-1:0] func_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         result_kind,
  output logic signed [DATA_WIDTH-1:0] point,
  output logic [1:0]                   status,
  output logic [COUNT_WIDTH-1:0]       iterations
);

  cfg_t       cfg;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  srie_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  srie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .out_stall (out_stall),
    .flags     (dp_status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (dp_cmd)
  );

  srie_datapath #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .cmd            (dp_cmd),
    .cfg            (cfg),
    .start_a        (start_a),
    .start_b        (start_b),
    .func_value     (func_value),
    .flags          (dp_status),
    .res_kind       (result_kind),
    .res_point      (point),
    .res_status     (status),
    .res_iterations (iterations)
  );

  // a waiting result word is never overwritten
  `SRIE_ASSERT_NOW(a_no_overwrite, dp_cmd.out_load, !out_valid || !out_stall, "result word overwritten")

  // the divider is idle whenever a new word can be taken
  `SRIE_ASSERT_NOW(a_div_idle, !in_stall, !dp_status.div_busy, "divider busy while ready")

  // a started division is running in the next cycle
  `SRIE_ASSERT_NEXT(a_div_runs, dp_cmd.div_start, dp_status.div_busy, "divider did not start")

  // requests always carry a clean status
  `SRIE_ASSERT_NOW(a_req_status, out_valid && (result_kind == KIND_REQUEST), status == STAT_OK, "request with status set")

endmodule

/* dv/tb_secant_root_iteration_engine.sv */
// ---------------------------------------------------------------------------
// tb_secant_root_iteration_engine
// Self-checking bench for the secant root engine. Tasks drive start and value
// words, with function values computed from the point the block asks for,
// so that searches run to a real end. A scoreboard class predicts every
// result word from its own secant model and compares each result field by
// field. Phases step through tolerance and limit settings, extremes included,
// and through sender and receiver idling patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_secant_root_iteration_engine;
  import srie_pkg::*;

  localparam int  CLK_HALF     = 2;
  localparam int  SETTLE_TICKS = 80;
  localparam int  CYCLE_LIMIT  = 1000000;
  localparam int  PHASES       = 8;
  localparam int  PHASE_WORDS  = 200;

  typedef struct {
    kind_t              kind;
    logic signed [31:0] pt;
    status_t            st;
    logic [15:0]        iters;
  } root_word_t;

  typedef enum int {FN_LINEAR, FN_QUAD, FN_FLAT, FN_NOISE} fn_shape_t;

  class root_scoreboard;
    logic [TOL_WIDTH-1:0]   value_tol = TOL_RESET;
    logic [TOL_WIDTH-1:0]   point_tol = TOL_RESET;
    logic [TOL_WIDTH-1:0]   slope_tol = TOL_RESET;
    logic [LIMIT_WIDTH-1:0] iter_limit = LIMIT_RESET;
    phase_t      phase = PH_IDLE;
    longint      cur_pt, cur_val, prv_pt, prv_val;
    logic [15:0] iter_cnt;
    longint      wanted_point;
    root_word_t  pending_words[$];
    int          errors, results, ignored, checked;
    int          finals[4];

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_WIDTH-1:0] data);
      case (idx)
        REG_VALUE_TOL: value_tol = data;
        REG_POINT_TOL: point_tol = data;
        REG_SLOPE_TOL: slope_tol = data;
        REG_MAX_ITER:  iter_limit = data[LIMIT_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function bit [63:0] mag(longint v);
      bit [63:0] m;
      m = v;
      if (v < 0) m = -m;
      return m;
    endfunction

    function longint sat(bit neg, bit [63:0] m);
      if (!neg) return (m > 64'h7fffffff) ? 64'sh7fffffff : longint'(m);
      if (m >= 64'h80000000) return -64'sh80000000;
      return -longint'(m);
    endfunction

    function void post_word(kind_t k, longint pt, status_t s);
      root_word_t w;
      w.kind  = k;
      w.pt    = pt[31:0];
      w.st    = s;
      w.iters = iter_cnt;
      pending_words.push_back(w);
      results++;
      if (k == KIND_REQUEST) wanted_point = pt;
      else finals[s]++;
    endfunction

    // one pass of the loop test: final word or request for the next point
    function void secant_check();
      longint     dx, dfv, q, p, nxt;
      bit [63:0]  qm, pm;
      if (mag(cur_val) > value_tol && iter_cnt < iter_limit) begin
        dx  = cur_pt - prv_pt;
        dfv = cur_val - prv_val;
        if (mag(dx) < point_tol) begin
          phase = PH_IDLE;
          post_word(KIND_ROOT, cur_pt, STAT_SAME_POINT);
        end else if (mag(dfv) < slope_tol || dfv == 0) begin
          phase = PH_IDLE;
          post_word(KIND_ROOT, cur_pt, STAT_FLAT_SLOPE);
        end else begin
          qm  = (mag(cur_val) << 16) / mag(dfv);
          q   = sat((cur_val < 0) != (dfv < 0), qm);
          pm  = (mag(q) * mag(dx)) >> 16;
          p   = sat((q < 0) != (dx < 0), pm);
          nxt = cur_pt - p;
          nxt = sat(nxt < 0, mag(nxt));
          prv_pt  = cur_pt;
          prv_val = cur_val;
          cur_pt  = nxt;
          phase   = PH_ITER;
          post_word(KIND_REQUEST, nxt, STAT_OK);
        end
      end else begin
        phase = PH_IDLE;
        post_word(KIND_ROOT, cur_pt, (iter_cnt >= iter_limit) ? STAT_NO_CONVERGE : STAT_OK);
      end
    endfunction

    function void note_word(op_t op, logic signed [31:0] a, logic signed [31:0] b,
                            logic signed [31:0] f);
      longint t;
      if (op == OP_START) begin
        cur_pt   = a;
        prv_pt   = b;
        cur_val  = 0;
        prv_val  = 0;
        iter_cnt = '0;
        phase    = PH_WAIT_A;
        post_word(KIND_REQUEST, cur_pt, STAT_OK);
        return;
      end
      case (phase)
        PH_WAIT_A: begin
          cur_val = f;
          phase   = PH_WAIT_B;
          post_word(KIND_REQUEST, prv_pt, STAT_OK);
        end
        PH_WAIT_B: begin
          // smaller signed value becomes the current point
          if (cur_val > f) begin
            t       = cur_pt;
            cur_pt  = prv_pt;
            prv_pt  = t;
            prv_val = cur_val;
            cur_val = f;
          end else begin
            prv_val = f;
          end
          secant_check();
        end
        PH_ITER: begin
          cur_val = f;
          if (iter_cnt != 16'hffff) iter_cnt++;
          secant_check();
        end
        default: ignored++;
      endcase
    endfunction

    function void check_word(logic kind, logic signed [31:0] pt, logic [1:0] st,
                             logic [15:0] it);
      root_word_t w;
      if (pending_words.size() == 0) begin
        $error("result word with none expected: point %0d", pt);
        errors++;
        return;
      end
      w = pending_words.pop_front();
      checked++;
      if (kind !== w.kind) begin
        $error("result_kind: expected %0d, actual %0d", w.kind, kind);
        errors++;
      end
      if (pt !== w.pt) begin
        $error("point: expected %0d, actual %0d", w.pt, pt);
        errors++;
      end
      if (st !== w.st) begin
        $error("status: expected %0d, actual %0d", w.st, st);
        errors++;
      end
      if (it !== w.iters) begin
        $error("iterations: expected %0d, actual %0d", w.iters, it);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_words.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          wr_en = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0]    wr_index = '0;
  logic [CFG_DATA_WIDTH-1:0]     wr_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          operation = 1'b0;
  logic signed [31:0]            start_a = '0;
  logic signed [31:0]            start_b = '0;
  logic signed [31:0]            func_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          result_kind;
  logic signed [31:0]            point;
  logic [1:0]                    status;
  logic [15:0]                   iterations;

  root_scoreboard sb = new();

  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        quiet_left = 0;
  int        cycles = 0;
  fn_shape_t fn_kind;
  longint    fn_root, fn_gain, fn_offset;

  secant_root_iteration_engine dut (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .start_a(start_a), .start_b(start_b),
    .func_value(func_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .point(point), .status(status),
    .iterations(iterations)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_word(result_kind, point, status, iterations);
  end

  // receiver back-pressure, with the odd quiet stretch
  always @(negedge clk) begin
    if (quiet_left > 0) begin
      quiet_left--;
      out_stall = 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) quiet_left = $urandom_range(20, 80);
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic longint clip(longint v, longint lim);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic signed [31:0] eval_fn(longint x);
    longint d, y;
    d = x - fn_root;
    case (fn_kind)
      FN_LINEAR: begin
        d = clip(d, longint'(1) << 30);
        y = (d * fn_gain) >>> 16;
      end
      FN_QUAD: begin
        d = clip(d, longint'(1) << 23);
        y = ((d * d) >>> 16) - fn_offset;
        if (fn_gain < 0) y = -y;
      end
      FN_FLAT: y = fn_offset;
      default: y = longint'($signed($urandom));
    endcase
    y = clip(y, longint'(1) << 31);
    return y[31:0];
  endfunction

  // entered and left at a falling edge
  task automatic put_word(input op_t op, input logic signed [31:0] a,
                          input logic signed [31:0] b, input logic signed [31:0] f);
    while (quiet_left == 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    operation  = op;
    start_a    = a;
    start_b    = b;
    func_value = f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(op, a, b, f);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_WIDTH-1:0] data);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = data;
    @(negedge clk);
    wr_en = 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic run_search(input int max_len);
    longint a, b;
    int     n, r;
    r = $urandom_range(0, 9);
    fn_kind   = (r < 4) ? FN_LINEAR : (r < 8) ? FN_QUAD : (r == 8) ? FN_FLAT : FN_NOISE;
    fn_root   = longint'($urandom_range(0, 2097152)) - 1048576;
    fn_gain   = longint'($urandom_range(1, 1048576));
    if ($urandom_range(0, 1)) fn_gain = -fn_gain;
    fn_offset = longint'($urandom_range(0, 262144));
    if ($urandom_range(0, 9) == 0) begin
      a = longint'($signed($urandom));
      b = longint'($signed($urandom));
    end else begin
      a = fn_root + longint'($urandom_range(0, 1048576)) - 524288;
      b = fn_root + longint'($urandom_range(0, 1048576)) - 524288;
    end
    put_word(OP_START, a[31:0], b[31:0], $urandom);
    n = 0;
    while (sb.phase != PH_IDLE && n < max_len) begin
      put_word(OP_VALUE, $urandom, $urandom, eval_fn(sb.wanted_point));
      n++;
    end
  endtask

  task automatic random_phase(input int words);
    int goal, half, r;
    bit held;
    goal = sb.results + words;
    half = sb.results + words / 2;
    held = 1'b0;
    while (sb.results < goal) begin
      r = $urandom_range(0, 99);
      if (r < 85)
        run_search(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 80);
      else if (r < 93)
        put_word(OP_VALUE, $urandom, $urandom, $urandom);
      else
        put_word(OP_START, $urandom, $urandom, $urandom);
      if (!held && sb.results >= half) begin
        wait_drained();
        held = 1'b1;
      end
    end
  endtask

  task automatic apply_setting(input int ph);
    logic [CFG_DATA_WIDTH-1:0] vt, pt, st;
    logic [LIMIT_WIDTH-1:0]    mi;
    case (ph)
      0: begin vt = 31'd66; pt = 31'd66; st = 31'd66; mi = 16'd50; end
      1: begin vt = '0; pt = '0; st = '0; mi = 16'hffff; end
      2: begin vt = '1; pt = '1; st = '1; mi = '0; end
      3: begin
        vt = CFG_DATA_WIDTH'($urandom_range(0, 1000));
        pt = CFG_DATA_WIDTH'($urandom_range(0, 1000));
        st = CFG_DATA_WIDTH'($urandom_range(0, 1000));
        mi = LIMIT_WIDTH'($urandom_range(1, 6));
      end
      4: begin vt = 31'd66; pt = 31'd66; st = '0; mi = 16'd50; end
      5: begin
        vt = CFG_DATA_WIDTH'($urandom_range(0, 1048576));
        pt = CFG_DATA_WIDTH'($urandom_range(0, 1048576));
        st = CFG_DATA_WIDTH'($urandom_range(0, 1048576));
        mi = LIMIT_WIDTH'($urandom_range(0, 100));
      end
      6: begin vt = 31'd1000; pt = 31'd10; st = 31'd10; mi = 16'd20; end
      default: begin vt = 31'd66; pt = 31'd66; st = 31'd66; mi = 16'd50; end
    endcase
    cfg_write(REG_VALUE_TOL, vt);
    cfg_write(REG_POINT_TOL, pt);
    cfg_write(REG_SLOPE_TOL, st);
    cfg_write(REG_MAX_ITER, {{(CFG_DATA_WIDTH-LIMIT_WIDTH){1'b0}}, mi});
    case (ph % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 70; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 70; end
      default: begin send_idle_pct = 23; stall_pct = 23; end
    endcase
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // value with nothing in progress is dropped
    put_word(OP_VALUE, 32'sh0, 32'sh0, 32'sh7fffffff);
    // extreme start points and values, then a root found
    put_word(OP_START, 32'sh7fffffff, 32'sh80000000, 32'sh0);
    put_word(OP_VALUE, 32'sh0, 32'sh0, 32'sh80000000);
    put_word(OP_VALUE, 32'sh0, 32'sh0, 32'sh7fffffff);
    put_word(OP_VALUE, 32'sh0, 32'sh0, 32'sh0);
    // points too close together
    put_word(OP_START, 32'sh10000, 32'sh10020, 32'sh0);
    put_word(OP_VALUE, 32'sh0, 32'sh0, 32'sh50000);
    put_word(OP_VALUE, 32'sh0, 32'sh0, 32'sh60000);
    // values too close together
    put_word(OP_START, 32'sh10000, 32'sh30000, 32'sh0);
    put_word(OP_VALUE, 32'sh0, 32'sh0, 32'sh40000);
    put_word(OP_VALUE, 32'sh0, 32'sh0, 32'sh40010);
    // restart part way through a search
    put_word(OP_START, -32'sh20000, 32'sh20000, 32'sh0);
    put_word(OP_VALUE, 32'sh0, 32'sh0, -32'sh10000);
    put_word(OP_START, 32'sh0, 32'sh10000, 32'sh0);
    put_word(OP_VALUE, 32'sh0, 32'sh0, -32'sh8000);
    put_word(OP_VALUE, 32'sh0, 32'sh0, 32'sh8000);
    put_word(OP_VALUE, 32'sh0, 32'sh0, 32'sh50);
    put_word(OP_VALUE, 32'sh0, 32'sh0, 32'sh0);
    // value right at the tolerance counts as a root
    put_word(OP_START, 32'sh0, 32'sh10000, 32'sh0);
    put_word(OP_VALUE, 32'sh0, 32'sh0, 32'sh42);
    put_word(OP_VALUE, 32'sh0, 32'sh0, 32'shc8);
    put_word(OP_VALUE, 32'shffffffff, 32'shffffffff, 32'sh80000000);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      apply_setting(ph);
      random_phase(PHASE_WORDS);
      wait_drained();
    end

    $display("checked %0d result words, %0d searches ended, %0d value words dropped",
             sb.checked, sb.finals[0] + sb.finals[1] + sb.finals[2] + sb.finals[3],
             sb.ignored);
    $display("endings: converged %0d, same point %0d, flat slope %0d, limit hit %0d",
             sb.finals[STAT_OK], sb.finals[STAT_SAME_POINT], sb.finals[STAT_FLAT_SLOPE],
             sb.finals[STAT_NO_CONVERGE]);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
